// File: src/gcfw_pkg.sv
// Package: shared constants and types for the graph center block.
`default_nettype none
package gcfw_pkg;

  localparam int NCW = 7;

  localparam logic [NCW-1:0] UNREACH = 7'd127;
  localparam logic [NCW-1:0] DIST_ONE = 7'd1;

  localparam logic CMD_EDGE    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_EDGE2   = 10'b0000000010,
    S_FW_ROW  = 10'b0000000100,
    S_FW_COL  = 10'b0000001000,
    S_FW_WAIT = 10'b0000010000,
    S_EC_RUN  = 10'b0000100000,
    S_EC_WAIT = 10'b0001000000,
    S_EM_RD   = 10'b0010000000,
    S_EM_CHK  = 10'b0100000000,
    S_CLEAR   = 10'b1000000000
  } state_t;

endpackage
`default_nettype wire

// File: src/gcfw_ifs.sv
// Channel interfaces: edge/command input, center results, node count write.
`default_nettype none
interface gcfw_in_if;
  import gcfw_pkg::*;
  logic           valid;
  logic           ready;
  logic           cmd;
  logic [NCW-1:0] node_a;
  logic [NCW-1:0] node_b;
  modport source (output valid, output cmd, output node_a, output node_b, input ready);
  modport sink   (input valid, input cmd, input node_a, input node_b, output ready);
endinterface

interface gcfw_out_if;
  import gcfw_pkg::*;
  logic           valid;
  logic           ready;
  logic [NCW-1:0] center_score;
  logic [NCW-1:0] center_count;
  logic [NCW-1:0] center_node;
  logic           is_last;
  modport source (output valid, output center_score, output center_count,
                  output center_node, output is_last, input ready);
  modport sink   (input valid, input center_score, input center_count,
                  input center_node, input is_last, output ready);
endinterface

interface gcfw_cfg_if;
  import gcfw_pkg::*;
  logic           valid;
  logic           ready;
  logic [NCW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/gcfw_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module gcfw_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end
endmodule
`default_nettype wire

// File: src/graph_center_floyd_warshall.sv
// Top level: graph center by Floyd-Warshall over a distance RAM.
//
//  channel  dir  payload                                          
//  in_ch    in   cmd, node_a, node_b                             
//  out_ch   out  center_score, center_count, center_node, is_last 
//  cfg_ch   in   data (node_count)                                
//
// Edge item: if in range, written to (a,b) and then mirrored to (b,a) through the one write port.
// Compute item: relaxation passes, then the eccentricity scan, then the emit scan
//   (which output stalls can hold), then the clear sweep.
// Reset and every compute end in a sweep of the whole distance RAM to unreachable;
//   no item is taken meanwhile.
// Eccentricity of node i is kept on the diagonal entry (i,i) once row i is scanned.
`default_nettype none
module graph_center_floyd_warshall #(
  parameter int MAX_NODES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  gcfw_in_if.sink     in_ch,
  gcfw_out_if.source  out_ch,
  gcfw_cfg_if.sink    cfg_ch
);
  import gcfw_pkg::*;

  localparam int IDXW  = $clog2(MAX_NODES);
  localparam int AW    = 2 * IDXW;
  localparam int DEPTH = 1 << AW;

  state_t          state_r, state_nxt;
  logic [NCW-1:0]  node_count_r, node_count_nxt;
  logic [IDXW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IDXW-1:0] ea_r, ea_nxt, eb_r, eb_nxt;
  logic [NCW-1:0]  dik_r, dik_nxt;
  logic            cap_r, cap_nxt;
  logic            fw_vld_r, fw_vld_nxt;
  logic [AW-1:0]   fw_waddr_r, fw_waddr_nxt;
  logic            ec_vld_r, ec_vld_nxt;
  logic            ec_first_r, ec_first_nxt;
  logic            ec_last_r, ec_last_nxt;
  logic            ec_diag_r, ec_diag_nxt;
  logic [IDXW-1:0] ec_row_r, ec_row_nxt;
  logic [NCW-1:0]  far_r, far_nxt;
  logic [NCW-1:0]  best_score_r, best_score_nxt;
  logic [NCW-1:0]  best_count_r, best_count_nxt;
  logic [NCW-1:0]  emit_cnt_r, emit_cnt_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic [NCW-1:0]  out_score_r, out_score_nxt;
  logic [NCW-1:0]  out_count_r, out_count_nxt;
  logic [NCW-1:0]  out_node_r, out_node_nxt;
  logic            out_last_r, out_last_nxt;

  logic            we;
  logic [AW-1:0]   waddr, ra_addr, rb_addr;
  logic [NCW-1:0]  wdata, rd_a, rd_b;

  logic [NCW-1:0]  n_eff, n_m1, am1, bm1;
  logic [IDXW-1:0] nlast;
  logic            in_acc, a_ok, b_ok, i_last, j_last, k_last, match;
  logic [NCW:0]    sum;
  logic [NCW-1:0]  via, relax, far_cur, far_new;

  gcfw_ram #(.WIDTH(NCW), .DEPTH(DEPTH)) u_dist (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .ra_addr (ra_addr),
    .ra_data (rd_a),
    .rb_addr (rb_addr),
    .rb_data (rd_b)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_vld_r;
  assign out_ch.center_score = out_score_r;
  assign out_ch.center_count = out_count_r;
  assign out_ch.center_node  = out_node_r;
  assign out_ch.is_last      = out_last_r;

  always_comb begin
    if (node_count_r == '0) begin
      n_eff = NCW'(1);
    end else if (node_count_r > NCW'(MAX_NODES)) begin
      n_eff = NCW'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  assign n_m1   = n_eff - NCW'(1);
  assign nlast  = n_m1[IDXW-1:0];
  assign in_acc = in_ch.valid && in_ch.ready;
  assign a_ok   = (in_ch.node_a != '0) && (in_ch.node_a <= n_eff);
  assign b_ok   = (in_ch.node_b != '0) && (in_ch.node_b <= n_eff);
  assign am1    = in_ch.node_a - NCW'(1);
  assign bm1    = in_ch.node_b - NCW'(1);
  assign i_last = (i_r == nlast);
  assign j_last = (j_r == nlast);
  assign k_last = (k_r == nlast);
  assign match  = (rd_b == best_score_r);

  // relaxation: d[i][j] = min(d[i][j], d[i][k] + d[k][j]), saturating
  assign sum   = {1'b0, dik_r} + {1'b0, rd_a};
  assign via   = (sum > {1'b0, UNREACH}) ? UNREACH : sum[NCW-1:0];
  assign relax = (via < rd_b) ? via : rd_b;

  // row maximum, diagonal skipped
  assign far_cur = ec_first_r ? '0 : far_r;
  assign far_new = (ec_diag_r || (rd_b <= far_cur)) ? far_cur : rd_b;

  always_comb begin
    state_nxt      = state_r;
    node_count_nxt = node_count_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    ea_nxt         = ea_r;
    eb_nxt         = eb_r;
    dik_nxt        = dik_r;
    cap_nxt        = 1'b0;
    fw_vld_nxt     = 1'b0;
    fw_waddr_nxt   = fw_waddr_r;
    ec_vld_nxt     = 1'b0;
    ec_first_nxt   = ec_first_r;
    ec_last_nxt    = ec_last_r;
    ec_diag_nxt    = ec_diag_r;
    ec_row_nxt     = ec_row_r;
    far_nxt        = far_r;
    best_score_nxt = best_score_r;
    best_count_nxt = best_count_r;
    emit_cnt_nxt   = emit_cnt_r;
    clr_nxt        = clr_r;
    out_vld_nxt    = out_vld_r;
    out_score_nxt  = out_score_r;
    out_count_nxt  = out_count_r;
    out_node_nxt   = out_node_r;
    out_last_nxt   = out_last_r;
    ra_addr        = {i_r, k_r};
    rb_addr        = {i_r, j_r};
    we             = 1'b0;
    waddr          = '0;
    wdata          = '0;

    if (cfg_ch.valid && cfg_ch.ready) begin
      node_count_nxt = cfg_ch.data;
    end

    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    if (ec_vld_r) begin
      far_nxt = far_new;
      if (ec_last_r) begin
        if (best_count_r == '0 || far_new < best_score_r) begin
          best_score_nxt = far_new;
          best_count_nxt = NCW'(1);
        end else if (far_new == best_score_r) begin
          best_count_nxt = best_count_r + NCW'(1);
        end
      end
    end

    // single write port
    if (state_r == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_r;
      wdata = UNREACH;
    end else if (state_r == S_IDLE && in_acc && in_ch.cmd == CMD_EDGE && a_ok && b_ok) begin
      we    = 1'b1;
      waddr = {am1[IDXW-1:0], bm1[IDXW-1:0]};
      wdata = DIST_ONE;
    end else if (state_r == S_EDGE2) begin
      we    = 1'b1;
      waddr = {eb_r, ea_r};
      wdata = DIST_ONE;
    end else if (fw_vld_r) begin
      we    = 1'b1;
      waddr = fw_waddr_r;
      wdata = relax;
    end else if (ec_vld_r && ec_last_r) begin
      we    = 1'b1;
      waddr = {ec_row_r, ec_row_r};
      wdata = far_new;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.cmd == CMD_COMPUTE) begin
            i_nxt          = '0;
            j_nxt          = '0;
            k_nxt          = '0;
            best_score_nxt = UNREACH;
            best_count_nxt = '0;
            emit_cnt_nxt   = '0;
            state_nxt      = S_FW_ROW;
          end else if (a_ok && b_ok) begin
            ea_nxt    = am1[IDXW-1:0];
            eb_nxt    = bm1[IDXW-1:0];
            state_nxt = S_EDGE2;
          end
        end
      end
      S_EDGE2: begin
        state_nxt = S_IDLE;
      end
      S_FW_ROW: begin
        ra_addr   = {i_r, k_r};
        cap_nxt   = 1'b1;
        j_nxt     = '0;
        state_nxt = S_FW_COL;
      end
      S_FW_COL: begin
        ra_addr      = {k_r, j_r};
        rb_addr      = {i_r, j_r};
        fw_vld_nxt   = 1'b1;
        fw_waddr_nxt = {i_r, j_r};
        if (cap_r) begin
          dik_nxt = rd_a;
        end
        if (j_last) begin
          j_nxt = '0;
          if (i_last) begin
            i_nxt = '0;
            if (k_last) begin
              state_nxt = S_FW_WAIT;
            end else begin
              k_nxt     = k_r + IDXW'(1);
              state_nxt = S_FW_ROW;
            end
          end else begin
            i_nxt     = i_r + IDXW'(1);
            state_nxt = S_FW_ROW;
          end
        end else begin
          j_nxt = j_r + IDXW'(1);
        end
      end
      S_FW_WAIT: begin
        i_nxt     = '0;
        j_nxt     = '0;
        state_nxt = S_EC_RUN;
      end
      S_EC_RUN: begin
        rb_addr      = {i_r, j_r};
        ec_vld_nxt   = 1'b1;
        ec_first_nxt = (j_r == '0);
        ec_last_nxt  = j_last;
        ec_diag_nxt  = (j_r == i_r);
        ec_row_nxt   = i_r;
        if (j_last) begin
          j_nxt = '0;
          if (i_last) begin
            i_nxt     = '0;
            state_nxt = S_EC_WAIT;
          end else begin
            i_nxt = i_r + IDXW'(1);
          end
        end else begin
          j_nxt = j_r + IDXW'(1);
        end
      end
      S_EC_WAIT: begin
        state_nxt = S_EM_RD;
      end
      S_EM_RD: begin
        rb_addr   = {i_r, i_r};
        state_nxt = S_EM_CHK;
      end
      S_EM_CHK: begin
        rb_addr = {i_r, i_r};
        if (!(match && out_vld_r && !out_ch.ready)) begin
          if (match) begin
            out_vld_nxt   = 1'b1;
            out_score_nxt = best_score_r;
            out_count_nxt = best_count_r;
            out_node_nxt  = {{(NCW-IDXW){1'b0}}, i_r} + NCW'(1);
            out_last_nxt  = ((emit_cnt_r + NCW'(1)) == best_count_r);
            emit_cnt_nxt  = emit_cnt_r + NCW'(1);
          end
          if (i_last) begin
            clr_nxt   = '0;
            state_nxt = S_CLEAR;
          end else begin
            i_nxt     = i_r + IDXW'(1);
            state_nxt = S_EM_RD;
          end
        end
      end
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      node_count_r <= NCW'(1);
      best_score_r <= UNREACH;
      best_count_r <= '0;
      cap_r        <= 1'b0;
      fw_vld_r     <= 1'b0;
      ec_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      node_count_r <= node_count_nxt;
      best_score_r <= best_score_nxt;
      best_count_r <= best_count_nxt;
      cap_r        <= cap_nxt;
      fw_vld_r     <= fw_vld_nxt;
      ec_vld_r     <= ec_vld_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    ea_r        <= ea_nxt;
    eb_r        <= eb_nxt;
    dik_r       <= dik_nxt;
    fw_waddr_r  <= fw_waddr_nxt;
    ec_first_r  <= ec_first_nxt;
    ec_last_r   <= ec_last_nxt;
    ec_diag_r   <= ec_diag_nxt;
    ec_row_r    <= ec_row_nxt;
    far_r       <= far_nxt;
    emit_cnt_r  <= emit_cnt_nxt;
    out_score_r <= out_score_nxt;
    out_count_r <= out_count_nxt;
    out_node_r  <= out_node_nxt;
    out_last_r  <= out_last_nxt;
  end

`ifndef SYNTH
  a_pipes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(fw_vld_r && ec_vld_r))
    else $error("relaxation and eccentricity pipelines both active");

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !(fw_vld_r || ec_vld_r))
    else $error("pipeline write during clearing sweep");

  a_emit_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EM_CHK && match) |-> (emit_cnt_r < best_count_r))
    else $error("more center nodes than counted");

  a_emit_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && $past(state_r) == S_EM_CHK) |-> (emit_cnt_r == best_count_r))
    else $error("emitted count differs from best count");

  a_best_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EM_RD || state_r == S_EM_CHK) |-> (best_count_r != '0))
    else $error("emit phase without a best node");
`endif

endmodule
`default_nettype wire
